// ===== hdl/tlf_pkg.sv =====
`default_nettype none

package tlf_pkg;

  // Line number width in decimal digits
  localparam int NumDigits = 6;
  localparam int DigitsW   = 4 * NumDigits;

  // Places within one output run: digits, tab, caret or dollar, final byte
  localparam int PosTab    = NumDigits;
  localparam int PosPrefix = NumDigits + 1;
  localparam int PosChar   = NumDigits + 2;
  localparam int PosW      = $clog2(NumDigits + 3);

  // Configuration port geometry
  localparam int NumRegs  = 6;
  localparam int CfgAddrW = $clog2(4 * NumRegs);
  localparam int CfgDataW = 32;
  localparam int RegIdxW  = CfgAddrW - 2;

  // Character codes
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChUpperI = 8'h49;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChCtlTop = 8'h20;
  localparam logic [7:0] CtlShift = 8'h40;
  localparam logic [3:0] DigitHi  = 4'h3;

  localparam logic [DigitsW-1:0] BcdOne = DigitsW'(1);
  localparam logic [1:0]         BudgetFull = 2'd2;

  typedef enum logic [RegIdxW-1:0] {
    REG_NUMBER_ALL      = RegIdxW'(0),
    REG_NUMBER_NONBLANK = RegIdxW'(1),
    REG_SQUEEZE_BLANK   = RegIdxW'(2),
    REG_SHOW_ENDS       = RegIdxW'(3),
    REG_SHOW_NONPRINT   = RegIdxW'(4),
    REG_SHOW_TABS       = RegIdxW'(5)
  } tlf_reg_t;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_nonprint;
    logic show_tabs;
  } tlf_cfg_t;

  // Description of the output run one input byte causes
  typedef struct packed {
    logic               shown;
    logic               put_num;
    logic               has_prefix;
    logic [7:0]         prefix_byte;
    logic [7:0]         final_byte;
    logic [DigitsW-1:0] digits;
  } tlf_run_t;

  // Add one to a BCD number, holding at all nines
  function automatic logic [DigitsW-1:0] bcd_increment(input logic [DigitsW-1:0] v);
    logic [DigitsW-1:0] r;
    logic               carry;
    logic               all_nines;
    all_nines = 1'b1;
    r         = v;
    carry     = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (v[4*i +: 4] != 4'd9) all_nines = 1'b0;
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return all_nines ? v : r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tlf_line_ctl.sv =====
`default_nettype none

module tlf_line_ctl import tlf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tlf_cfg_t   cfg,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       new_file,
  output tlf_run_t        run
);

  logic [DigitsW-1:0] digits_r, digits_nxt, digits_eff;
  logic               line_start_r, line_start_nxt, line_start_eff;
  logic [1:0]         budget_r, budget_nxt, budget_eff;
  logic               is_nl;
  logic               is_ctl;

  // Decide the run for the offered byte and the next line state
  always_comb begin
    digits_eff     = new_file ? BcdOne : digits_r;
    line_start_eff = new_file | line_start_r;
    budget_eff     = new_file ? BudgetFull : budget_r;
    is_nl          = (data_byte == ChNl);
    is_ctl         = (data_byte < ChCtlTop) && (data_byte != ChTab) && !is_nl;

    // Count down on blank lines while squeezing, refill on anything else
    if (cfg.squeeze_blank && is_nl && line_start_eff) begin
      budget_nxt = (budget_eff != 2'd0) ? budget_eff - 2'd1 : 2'd0;
    end else begin
      budget_nxt = BudgetFull;
    end

    run.shown   = (budget_nxt != 2'd0);
    run.digits  = digits_eff;
    run.put_num = run.shown && line_start_eff &&
                  (cfg.number_nonblank ? !is_nl : cfg.number_all);

    run.has_prefix  = 1'b0;
    run.prefix_byte = ChCaret;
    run.final_byte  = data_byte;
    if (cfg.show_ends && is_nl) begin
      run.has_prefix  = 1'b1;
      run.prefix_byte = ChDollar;
    end else if (cfg.show_nonprint && is_ctl) begin
      run.has_prefix = 1'b1;
      run.final_byte = data_byte + CtlShift;
    end else if (cfg.show_nonprint && data_byte == ChDel) begin
      run.has_prefix = 1'b1;
      run.final_byte = ChQmark;
    end else if (cfg.show_tabs && data_byte == ChTab) begin
      run.has_prefix = 1'b1;
      run.final_byte = ChUpperI;
    end

    digits_nxt     = run.put_num ? bcd_increment(digits_eff) : digits_eff;
    line_start_nxt = is_nl;
  end

  // Commit line state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r     <= BcdOne;
      line_start_r <= 1'b1;
      budget_r     <= BudgetFull;
    end else if (accept) begin
      digits_r     <= digits_nxt;
      line_start_r <= line_start_nxt;
      budget_r     <= budget_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/text_line_formatter_core.sv =====
// The first output byte of a request goes through the run register, then the output register.
// Throughput: one output byte per cycle while out_ready holds; a request yields 1 to 9
// bytes, drained from the run register into the output register, and a new request is
// taken as the last byte of the previous run drains. A request that yields nothing leaves the run register free.
// Reset (rst_n, synchronous): all options off, line number 1, at line start.
`default_nettype none

module text_line_formatter_core import tlf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_new_file,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_out_byte,
  output logic                     out_last_of_run,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0]      cfg_prdata,
  output logic                     cfg_pready
);

  tlf_cfg_t          cfg_r;
  tlf_reg_t          reg_idx;
  logic              cfg_write;

  tlf_run_t          run_in;
  tlf_run_t          run_r;
  logic              run_valid_r, run_valid_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt, pos_start;
  logic              accept;
  logic              load_out;
  logic              emit;
  logic              run_done;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic [7:0]        emit_byte;
  logic [7:0]        num_char;
  logic              lead_zero;

  // Configuration registers
  assign reg_idx    = tlf_reg_t'(cfg_paddr[CfgAddrW-1:2]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_NUMBER_ALL:      cfg_r.number_all      <= cfg_pwdata[0];
        REG_NUMBER_NONBLANK: cfg_r.number_nonblank <= cfg_pwdata[0];
        REG_SQUEEZE_BLANK:   cfg_r.squeeze_blank   <= cfg_pwdata[0];
        REG_SHOW_ENDS:       cfg_r.show_ends       <= cfg_pwdata[0];
        REG_SHOW_NONPRINT:   cfg_r.show_nonprint   <= cfg_pwdata[0];
        REG_SHOW_TABS:       cfg_r.show_tabs       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUMBER_ALL:      cfg_prdata = CfgDataW'(cfg_r.number_all);
      REG_NUMBER_NONBLANK: cfg_prdata = CfgDataW'(cfg_r.number_nonblank);
      REG_SQUEEZE_BLANK:   cfg_prdata = CfgDataW'(cfg_r.squeeze_blank);
      REG_SHOW_ENDS:       cfg_prdata = CfgDataW'(cfg_r.show_ends);
      REG_SHOW_NONPRINT:   cfg_prdata = CfgDataW'(cfg_r.show_nonprint);
      REG_SHOW_TABS:       cfg_prdata = CfgDataW'(cfg_r.show_tabs);
      default:             cfg_prdata = '0;
    endcase
  end

  // Line state and run decision
  tlf_line_ctl u_line_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .data_byte (in_data_byte),
    .new_file  (in_new_file),
    .run       (run_in)
  );

  // Handshake: take a request when the run register is free or drains now
  assign load_out = !out_valid_r || out_ready;
  assign emit     = run_valid_r && load_out;
  assign run_done = emit && (pos_r == PosW'(PosChar));
  assign in_ready = !run_valid_r || run_done;
  assign accept   = in_valid && in_ready;

  // Run register: first place and stepping through the run
  always_comb begin
    if (run_in.put_num) begin
      pos_start = '0;
    end else if (run_in.has_prefix) begin
      pos_start = PosW'(PosPrefix);
    end else begin
      pos_start = PosW'(PosChar);
    end

    run_valid_nxt = run_valid_r;
    pos_nxt       = pos_r;
    if (accept && run_in.shown) begin
      run_valid_nxt = 1'b1;
      pos_nxt       = pos_start;
    end else if (run_done) begin
      run_valid_nxt = 1'b0;
    end else if (emit) begin
      if (pos_r == PosW'(PosTab)) begin
        pos_nxt = run_r.has_prefix ? PosW'(PosPrefix) : PosW'(PosChar);
      end else begin
        pos_nxt = pos_r + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      run_valid_r <= run_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && run_in.shown) begin
      run_r <= run_in;
    end
  end

  // Pick the digit or pad space at the current place, most significant first
  always_comb begin
    num_char  = ChSpace;
    lead_zero = 1'b1;
    for (int p = 0; p < NumDigits; p++) begin
      lead_zero = lead_zero && (run_r.digits[4*(NumDigits-1-p) +: 4] == 4'd0);
      if (pos_r == PosW'(p)) begin
        if (lead_zero && p != NumDigits - 1) begin
          num_char = ChSpace;
        end else begin
          num_char = {DigitHi, run_r.digits[4*(NumDigits-1-p) +: 4]};
        end
      end
    end

    if (pos_r == PosW'(PosChar)) begin
      emit_byte = run_r.final_byte;
    end else if (pos_r == PosW'(PosPrefix)) begin
      emit_byte = run_r.prefix_byte;
    end else if (pos_r == PosW'(PosTab)) begin
      emit_byte = ChTab;
    end else begin
      emit_byte = num_char;
    end
  end

  // Output register
  assign out_valid_nxt = load_out ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= (pos_r == PosW'(PosChar));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_byte    = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ===== sim/text_line_formatter_core_checker.sv =====
`timescale 1ns / 100ps

module text_line_formatter_core_checker import tlf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_new_file,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [7:0]          out_out_byte,
  input  logic                out_last_of_run,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output int                  error_count,
  output int                  pending_count,
  output int                  request_count,
  output int                  byte_count,
  output int                  squeezed_count
);

  localparam int unsigned NumberMax = 10 ** NumDigits - 1;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } fmt_byte_t;

  // Shadow of the option registers and of the line state
  tlf_cfg_t    opt;
  int unsigned line_no;
  logic        line_start;
  logic [1:0]  blank_left;

  fmt_byte_t   expected_q[$];
  fmt_byte_t   got;
  fmt_byte_t   want;
  int          mismatches = 0;
  int          requests = 0;
  int          bytes_out = 0;
  int          squeezed = 0;

  task automatic report_mismatch(input string what, input logic [7:0] exp_val,
                                 input logic [7:0] got_val);
    mismatches++;
    if (mismatches <= 30) begin
      $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_val, got_val);
    end
  endtask

  function automatic void push_fmt_byte(input logic [7:0] text);
    expected_q.push_back('{text: text, last: 1'b0});
  endfunction

  // Work out the output run that one request causes and queue it
  task automatic format_request(input logic [7:0] data, input logic restart);
    logic [7:0]  ch;
    logic        is_nl;
    logic        shown;
    logic        leading;
    int unsigned divisor;
    int unsigned digit;
    int          start_size;
    fmt_byte_t   tail;
    ch         = data;
    is_nl      = (data == ChNl);
    start_size = expected_q.size();
    if (restart) begin
      line_no    = 1;
      line_start = 1'b1;
      blank_left = BudgetFull;
    end
    // Count down the budget on empty lines, reload on anything else
    if (opt.squeeze_blank && is_nl && line_start) begin
      if (blank_left != 2'd0) blank_left = blank_left - 2'd1;
    end else begin
      blank_left = BudgetFull;
    end
    shown = (blank_left != 2'd0);
    // Line number prefix: right-aligned, space padded, then a tab
    if (shown && line_start && (opt.number_nonblank ? !is_nl : opt.number_all)) begin
      leading = 1'b1;
      divisor = (NumberMax + 1) / 10;
      for (int pos = NumDigits - 1; pos >= 0; pos--) begin
        digit = (line_no / divisor) % 10;
        if (digit != 0 || pos == 0) leading = 1'b0;
        push_fmt_byte(leading ? ChSpace : {DigitHi, digit[3:0]});
        divisor = divisor / 10;
      end
      push_fmt_byte(ChTab);
      if (line_no < NumberMax) line_no++;
    end
    if (shown) begin
      if (opt.show_ends && is_nl) push_fmt_byte(ChDollar);
      if (opt.show_nonprint && ch < ChCtlTop && ch != ChTab && ch != ChNl) begin
        push_fmt_byte(ChCaret);
        ch = ch + CtlShift;
      end else if (opt.show_nonprint && ch == ChDel) begin
        push_fmt_byte(ChCaret);
        ch = ChQmark;
      end
      if (opt.show_tabs && ch == ChTab) begin
        push_fmt_byte(ChCaret);
        ch = ChUpperI;
      end
      push_fmt_byte(ch);
    end else begin
      squeezed++;
    end
    line_start = is_nl;
    // Flag the final byte of the run
    if (expected_q.size() > start_size) begin
      tail      = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      opt        = '0;
      line_no    = 1;
      line_start = 1'b1;
      blank_left = BudgetFull;
      expected_q.delete();
    end else begin
      // Track option writes; unused indexes change nothing
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CfgAddrW-1:2])
          REG_NUMBER_ALL:      opt.number_all      = cfg_pwdata[0];
          REG_NUMBER_NONBLANK: opt.number_nonblank = cfg_pwdata[0];
          REG_SQUEEZE_BLANK:   opt.squeeze_blank   = cfg_pwdata[0];
          REG_SHOW_ENDS:       opt.show_ends       = cfg_pwdata[0];
          REG_SHOW_NONPRINT:   opt.show_nonprint   = cfg_pwdata[0];
          REG_SHOW_TABS:       opt.show_tabs       = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        requests++;
        format_request(in_data_byte, in_new_file);
      end
      // Compare each output byte with the oldest expectation
      if (out_valid && out_ready) begin
        bytes_out++;
        got = '{text: out_out_byte, last: out_last_of_run};
        if (expected_q.size() == 0) begin
          report_mismatch("output byte with nothing pending", 8'h00, got.text);
        end else begin
          want = expected_q.pop_front();
          if (got.text !== want.text) report_mismatch("out_byte", want.text, got.text);
          if (got.last !== want.last) begin
            report_mismatch("last_of_run", {7'd0, want.last}, {7'd0, got.last});
          end
        end
      end
    end
    error_count    <= mismatches;
    pending_count  <= expected_q.size();
    request_count  <= requests;
    byte_count     <= bytes_out;
    squeezed_count <= squeezed;
  end

endmodule

// ===== sim/text_line_formatter_core_test.sv =====
`timescale 1ns / 100ps

module text_line_formatter_core_test;
  import tlf_pkg::*;

  localparam int LongHoldCycles = 120;
  localparam int RandomPhases   = 6;
  localparam int PhaseRequests  = 30;
  localparam logic [CfgAddrW-1:0] AddrSpare = CfgAddrW'(4 * NumRegs);

  typedef enum int {
    SINK_STEADY,
    SINK_HALF,
    SINK_MOSTLY,
    SINK_SPARSE
  } sink_mode_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_data_byte;
  logic                in_new_file;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          out_out_byte;
  logic                out_last_of_run;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  logic hold_request;
  int   burst_left = 0;
  int   option_sets = 0;
  int   error_count;
  int   pending_count;
  int   request_count;
  int   byte_count;
  int   squeezed_count;

  text_line_formatter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_new_file     (in_new_file),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  text_line_formatter_core_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_new_file     (in_new_file),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .request_count   (request_count),
    .byte_count      (byte_count),
    .squeezed_count  (squeezed_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // Drain side: stall on a pattern of modes, plus one long hold-off on request
  initial begin
    sink_mode_t mode;
    int         mode_left;
    logic       hold_served;
    out_ready   = 1'b0;
    mode        = SINK_STEADY;
    mode_left   = 0;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 40);
        end
        mode_left--;
        case (mode)
          SINK_STEADY: out_ready <= 1'b1;
          SINK_HALF:   out_ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one request, in bursts separated by random gaps
  task automatic offer_request(input logic [7:0] data, input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_new_file  <= restart;
    burst_left--;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected byte is out and the block is quiet
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] addr,
                                input logic [CfgDataW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Only bit 0 counts; the upper bits carry noise
  function automatic logic [CfgDataW-1:0] option_word(input logic enable);
    logic [CfgDataW-1:0] word;
    word    = $urandom();
    word[0] = enable;
    return word;
  endfunction

  task automatic apply_options(input tlf_cfg_t opts);
    write_register({REG_NUMBER_ALL, 2'b00},      option_word(opts.number_all));
    write_register({REG_NUMBER_NONBLANK, 2'b00}, option_word(opts.number_nonblank));
    write_register({REG_SQUEEZE_BLANK, 2'b00},   option_word(opts.squeeze_blank));
    write_register({REG_SHOW_ENDS, 2'b00},       option_word(opts.show_ends));
    write_register({REG_SHOW_NONPRINT, 2'b00},   option_word(opts.show_nonprint));
    write_register({REG_SHOW_TABS, 2'b00},       option_word(opts.show_tabs));
    write_register(AddrSpare, $urandom());
    option_sets++;
  endtask

  // Text-like byte mix: lines, tabs, control bytes, DEL and high bytes
  function automatic logic [7:0] pick_text_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 16) return ChNl;
    if (roll < 24) return ChTab;
    if (roll < 34) return 8'($urandom_range(0, 31));
    if (roll < 38) return ChDel;
    if (roll < 50) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  initial begin
    tlf_cfg_t   opts;
    logic [5:0] opt_bits;
    int         sent;
    int         blank_run;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_new_file  = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    hold_request = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Options at reset: plain pass-through, byte extremes
    offer_request(8'h00, 1'b0);
    offer_request(8'hFF, 1'b0);
    offer_request(8'h41, 1'b0);
    offer_request(ChNl, 1'b0);
    settle();

    // Everything on: nonblank numbering wins, blank runs squeezed, carets
    opts = '1;
    apply_options(opts);
    offer_request(ChNl, 1'b0);
    offer_request(ChNl, 1'b0);
    offer_request(ChNl, 1'b0);
    offer_request(ChNl, 1'b0);
    offer_request(ChTab, 1'b0);
    offer_request(8'h01, 1'b0);
    offer_request(8'h1F, 1'b0);
    offer_request(ChDel, 1'b0);
    offer_request(8'h80, 1'b0);
    offer_request(8'hFF, 1'b0);
    offer_request(8'h41, 1'b0);
    offer_request(ChNl, 1'b0);
    offer_request(8'h78, 1'b1);
    offer_request(ChNl, 1'b0);
    settle();

    // Number every line, blank ones included; tab and DEL pass raw
    opts = '0;
    opts.number_all = 1'b1;
    apply_options(opts);
    offer_request(ChNl, 1'b1);
    offer_request(ChNl, 1'b0);
    offer_request(8'h61, 1'b0);
    offer_request(ChTab, 1'b0);
    offer_request(ChDel, 1'b0);
    offer_request(ChNl, 1'b0);
    settle();

    // Random text under a fresh option set per phase
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) begin
        opts = '0;
      end else if (phase == 1) begin
        opts = '1;
      end else begin
        opt_bits = $urandom_range(0, 63);
        opts     = opt_bits;
      end
      apply_options(opts);
      if (phase == 2) hold_request <= 1'b1;
      sent = 0;
      while (sent < PhaseRequests) begin
        if ($urandom_range(0, 9) == 0) begin
          blank_run = $urandom_range(2, 5);
          repeat (blank_run) begin
            offer_request(ChNl, 1'b0);
            sent++;
          end
        end else begin
          offer_request(pick_text_byte(), $urandom_range(0, 31) == 0);
          sent++;
        end
      end
      settle();
    end

    $display("Run covered %0d requests and %0d output bytes over %0d option sets.",
             request_count, byte_count, option_sets);
    $display("%0d blank-line requests were squeezed away.", squeezed_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== text_line_formatter_core.f =====
hdl/tlf_pkg.sv
hdl/tlf_line_ctl.sv
hdl/text_line_formatter_core.sv
sim/text_line_formatter_core_checker.sv
sim/text_line_formatter_core_test.sv
